/* hw/rtl/dual_odometer_speed_estimator_assert.svh */
// ----------------------------------------------------------------------------
// Dual odometer speed estimator assertion macros
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_ODOMETER_SPEED_ESTIMATOR_ASSERT_SVH
`define DUAL_ODOMETER_SPEED_ESTIMATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DOS_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DOS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dos_pkg.sv */
// ----------------------------------------------------------------------------
// Dual odometer speed estimator package
// Widths, scale constants, command and divider types shared by the block.
// ----------------------------------------------------------------------------
package dos_pkg;

  // Field widths of the sensor report and the result word.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned VEL_W   = 32;
  localparam int unsigned MOVED_W = 40;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned TSUM_W  = 33;

  // Configuration register widths and indexes.
  localparam int unsigned DPT_W     = 16;
  localparam int unsigned TIMEOUT_W = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_TICK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_TIMEOUT = 1'd1;
  localparam logic [DPT_W-1:0]     DPT_RESET         = 16'd1000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 32'd100000;

  // Scale factors: two channels averaged times um->mm per us->s.
  localparam int unsigned SPEED_SCALE = 2000;
  localparam int unsigned CAP_SCALE   = 1000;
  localparam int unsigned DPT2K_W     = 27;
  localparam int unsigned DPT1K_W     = 26;

  // Exact distance moved: 33-bit tick sum times 17-bit signed distance.
  localparam int unsigned MOVED_X_W = 49;

  // Divider: 59-bit dividend, 32-bit divisor, 32-bit quotient or overflow.
  localparam int unsigned DEN_W = 32;
  localparam int unsigned NUM_W = 59;

  // Default depth of the command queue between front and back.
  localparam int unsigned FIFO_DEPTH = 2;

  // One classified report handed from the front to the back.
  typedef struct packed {
    logic signed [COUNT_W-1:0]   da;
    logic signed [COUNT_W-1:0]   db;
    logic [TIME_W-1:0]           dta;
    logic [TIME_W-1:0]           dtb;
    logic [TIME_W-1:0]           elapsed;
    logic                        upd_a;
    logic                        upd_b;
    logic                        stale;
    logic                        cap_en;
    logic signed [MOVED_X_W-1:0] moved;
    logic signed [TSUM_W-1:0]    tick_sum;
  } dos_cmd_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } dos_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             ovf;
    logic [DEN_W-1:0] quot;
  } dos_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_WAIT,
    ST_FINISH
  } dos_state_e;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_C
  } dos_phase_e;

endpackage

/* hw/rtl/dos_in_if.sv */
// ----------------------------------------------------------------------------
// Sensor report channel
// Valid/ready channel carrying one odometer report word.
// ----------------------------------------------------------------------------
interface dos_in_if;
  import dos_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         clock_now_us;
  logic signed [COUNT_W-1:0] count_a;
  logic [TIME_W-1:0]         time_a_us;
  logic signed [COUNT_W-1:0] count_b;
  logic [TIME_W-1:0]         time_b_us;

  modport source (
    output valid, clock_now_us, count_a, time_a_us, count_b, time_b_us,
    input  ready
  );

  modport sink (
    input  valid, clock_now_us, count_a, time_a_us, count_b, time_b_us,
    output ready
  );
endinterface

/* hw/rtl/dos_out_if.sv */
// ----------------------------------------------------------------------------
// Speed result channel
// Valid/ready channel carrying one velocity and distance result word.
// ----------------------------------------------------------------------------
interface dos_out_if;
  import dos_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VEL_W-1:0]   velocity_mm_s;
  logic signed [MOVED_W-1:0] moved_um;
  logic signed [TOTAL_W-1:0] total_um;
  logic signed [TSUM_W-1:0]  tick_sum;

  modport source (
    output valid, velocity_mm_s, moved_um, total_um, tick_sum,
    input  ready
  );

  modport sink (
    input  valid, velocity_mm_s, moved_um, total_um, tick_sum,
    output ready
  );
endinterface

/* hw/rtl/dos_front.sv */
// ----------------------------------------------------------------------------
// Report front end
// Accepts sensor reports, forms tick and time deltas against the stored
// report, classifies the report and pushes a command into the queue.
// ----------------------------------------------------------------------------
module dos_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  dos_in_if.sink                           in_i,
  input  logic [dos_pkg::DPT_W-1:0]        cfg_dpt_i,
  input  logic [dos_pkg::TIMEOUT_W-1:0]    cfg_timeout_i,
  input  logic                             full_i,
  output logic                             push_o,
  output dos_pkg::dos_cmd_t                cmd_o
);
  import dos_pkg::*;

  logic signed [COUNT_W-1:0] prev_ca_q, prev_cb_q;
  logic [TIME_W-1:0]         prev_ta_q, prev_tb_q;

  logic signed [COUNT_W-1:0] da, db;
  logic signed [COUNT_W:0]   dsum;
  logic signed [MOVED_X_W:0] moved_full;
  logic [TIME_W-1:0]         tick_now, tick_prev, elapsed;
  logic                      same_tick, stale;

  // A word is taken whenever the queue has room.
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Deltas against the previous report, modulo 2^32.
  assign da = in_i.count_a - prev_ca_q;
  assign db = in_i.count_b - prev_cb_q;

  // Exact distance moved this report.
  assign dsum       = {da[COUNT_W-1], da} + {db[COUNT_W-1], db};
  assign moved_full = dsum * $signed({1'b0, cfg_dpt_i});

  // Latest tick time now and before, and time since the stored latest tick.
  assign tick_now  = (in_i.time_a_us > in_i.time_b_us) ? in_i.time_a_us : in_i.time_b_us;
  assign tick_prev = (prev_ta_q > prev_tb_q) ? prev_ta_q : prev_tb_q;
  assign elapsed   = in_i.clock_now_us - tick_prev;
  assign same_tick = (tick_now == tick_prev);
  assign stale     = same_tick && (elapsed > cfg_timeout_i);

  // Command word for the back end.
  always_comb begin
    cmd_o.da       = da;
    cmd_o.db       = db;
    cmd_o.dta      = in_i.time_a_us - prev_ta_q;
    cmd_o.dtb      = in_i.time_b_us - prev_tb_q;
    cmd_o.elapsed  = elapsed;
    cmd_o.upd_a    = (in_i.time_a_us != prev_ta_q);
    cmd_o.upd_b    = (in_i.time_b_us != prev_tb_q);
    cmd_o.stale    = stale;
    cmd_o.cap_en   = same_tick && (elapsed != '0) && !stale;
    cmd_o.moved    = moved_full[MOVED_X_W-1:0];
    cmd_o.tick_sum = {in_i.count_a[COUNT_W-1], in_i.count_a}
                   + {in_i.count_b[COUNT_W-1], in_i.count_b};
  end

  // The stored report is replaced by every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ca_q <= '0;
      prev_cb_q <= '0;
      prev_ta_q <= '0;
      prev_tb_q <= '0;
    end else if (push_o) begin
      prev_ca_q <= in_i.count_a;
      prev_cb_q <= in_i.count_b;
      prev_ta_q <= in_i.time_a_us;
      prev_tb_q <= in_i.time_b_us;
    end
  end
endmodule

/* hw/rtl/dos_fifo.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dos_fifo #(
  parameter int unsigned DEPTH = dos_pkg::FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dos_pkg::dos_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output dos_pkg::dos_cmd_t data_o,
  output logic              empty_o
);
  import dos_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dos_cmd_t          mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

/* hw/rtl/dos_div.sv */
// ----------------------------------------------------------------------------
// Shared divider
// Restoring divider, one quotient bit per cycle. Flags overflow when the
// quotient does not fit in 32 bits, so only 32 steps are ever needed.
// ----------------------------------------------------------------------------
module dos_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dos_pkg::dos_div_req_t req_i,
  output dos_pkg::dos_div_rsp_t rsp_o
);
  import dos_pkg::*;

  localparam int unsigned HI_W  = NUM_W - DEN_W;
  localparam int unsigned CNT_W = $clog2(DEN_W);

  logic             busy_q, done_q, ovf_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, quo_q, den_q;

  logic [HI_W-1:0]  num_hi;
  logic             hi_ovf;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  // Overflow when the upper dividend part already reaches the divisor.
  assign num_hi = req_i.num[NUM_W-1:DEN_W];
  assign hi_ovf = ({{(DEN_W - HI_W){1'b0}}, num_hi} >= req_i.den);

  // One restoring step.
  assign trial = {rem_q, quo_q[DEN_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Sequencing of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= !hi_ovf;
        done_q <= hi_ovf;
        cnt_q  <= CNT_W'(DEN_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ovf_q <= hi_ovf;
      den_q <= req_i.den;
      rem_q <= {{(DEN_W - HI_W){1'b0}}, num_hi};
      quo_q <= req_i.num[DEN_W-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[DEN_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = quo_q;
endmodule

/* hw/rtl/dos_back.sv */
// ----------------------------------------------------------------------------
// Speed back end
// Pops commands, runs the channel speed and cap divisions on the shared
// divider, forms velocity and distance totals and holds the result word.
// ----------------------------------------------------------------------------
`include "dual_odometer_speed_estimator_assert.svh"

module dos_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dos_pkg::DPT_W-1:0]     cfg_dpt_i,
  input  logic                          empty_i,
  input  dos_pkg::dos_cmd_t             cmd_i,
  output logic                          pop_o,
  output dos_pkg::dos_div_req_t         div_req_o,
  input  dos_pkg::dos_div_rsp_t         div_rsp_i,
  dos_out_if.source                     out_o
);
  import dos_pkg::*;

  localparam logic [VEL_W-1:0]   S32_MAX = {1'b0, {(VEL_W - 1){1'b1}}};
  localparam logic [VEL_W-1:0]   S32_MIN = {1'b1, {(VEL_W - 1){1'b0}}};
  localparam logic [TOTAL_W-1:0] S48_MAX = {1'b0, {(TOTAL_W - 1){1'b1}}};
  localparam logic [TOTAL_W-1:0] S48_MIN = {1'b1, {(TOTAL_W - 1){1'b0}}};
  localparam logic [MOVED_W-1:0] S40_MAX = {1'b0, {(MOVED_W - 1){1'b1}}};
  localparam logic [MOVED_W-1:0] S40_MIN = {1'b1, {(MOVED_W - 1){1'b0}}};

  dos_state_e state_q, state_d;
  dos_phase_e ph_q, ph_d;

  dos_cmd_t                  cmd_q;
  logic [NUM_W-1:0]          num_q;
  logic [DEN_W-1:0]          den_q;
  logic [DPT1K_W-1:0]        cap_q;
  logic [DPT2K_W-1:0]        dpt2k_q;
  logic [DPT1K_W-1:0]        dpt1k_q;
  logic signed [VEL_W-1:0]   speed_a_q, speed_b_q;
  logic signed [TOTAL_W-1:0] total_q;
  logic                      out_valid_q, out_valid_d;
  logic signed [VEL_W-1:0]   vel_out_q;
  logic signed [MOVED_W-1:0] moved_out_q;
  logic signed [TSUM_W-1:0]  tsum_out_q;

  logic ld_cmd, ld_div, st_res, fin;

  // Saturate an unsigned quotient magnitude to a signed 32-bit speed.
  function automatic logic [VEL_W-1:0] sat_speed(logic [DEN_W-1:0] q, logic ovf,
                                                 logic neg);
    logic big;
    if (neg) begin
      big = ovf || (q > S32_MIN);
      return big ? S32_MIN : (~q + 1'b1);
    end else begin
      big = ovf || q[DEN_W-1];
      return big ? S32_MAX : q;
    end
  endfunction

  // Dividend and divisor for the current phase.
  logic signed [COUNT_W-1:0] dsel;
  logic [COUNT_W-1:0]        mag;
  logic [NUM_W-1:0]          prod, num_sel;
  logic [DEN_W-1:0]          den_sel;

  assign dsel = (ph_q == PH_A) ? cmd_q.da : cmd_q.db;
  assign mag  = dsel[COUNT_W-1] ? (~dsel + 1'b1) : dsel;
  assign prod = {{(NUM_W - COUNT_W){1'b0}}, mag} * {{(NUM_W - DPT2K_W){1'b0}}, dpt2k_q};

  always_comb begin
    unique case (ph_q)
      PH_A: begin
        num_sel = prod;
        den_sel = cmd_q.dta;
      end
      PH_B: begin
        num_sel = prod;
        den_sel = cmd_q.dtb;
      end
      PH_C: begin
        num_sel = {{(NUM_W - DPT1K_W){1'b0}}, dpt1k_q};
        den_sel = cmd_q.elapsed;
      end
      default: begin
        num_sel = prod;
        den_sel = cmd_q.elapsed;
      end
    endcase
  end

  // Velocity: mean of the channel speeds, then stale and cap handling.
  logic signed [VEL_W:0]   vsum, vavg;
  logic [VEL_W-1:0]        vel, vmag, cap_ext, vel_fin;

  assign vsum    = {speed_a_q[VEL_W-1], speed_a_q} + {speed_b_q[VEL_W-1], speed_b_q};
  assign vavg    = vsum + {{VEL_W{1'b0}}, vsum[VEL_W]};
  assign vel     = vavg[VEL_W:1];
  assign vmag    = vel[VEL_W-1] ? (~vel + 1'b1) : vel;
  assign cap_ext = {{(VEL_W - DPT1K_W){1'b0}}, cap_q};

  always_comb begin
    if (cmd_q.stale) begin
      vel_fin = '0;
    end else if (cmd_q.cap_en && (cap_ext < vmag)) begin
      vel_fin = vel[VEL_W-1] ? (~cap_ext + 1'b1) : cap_ext;
    end else begin
      vel_fin = vel;
    end
  end

  // Saturating distance total and moved-distance output.
  logic signed [TOTAL_W+1:0] tsum_wide;
  logic [TOTAL_W-1:0]        total_d;
  logic [MOVED_W-1:0]        moved_sat;
  logic                      tot_fits, mov_fits;

  assign tsum_wide = {{2{total_q[TOTAL_W-1]}}, total_q}
                   + {cmd_q.moved[MOVED_X_W-1], cmd_q.moved};
  assign tot_fits  = (&tsum_wide[TOTAL_W+1:TOTAL_W-1]) || !(|tsum_wide[TOTAL_W+1:TOTAL_W-1]);
  assign total_d   = tot_fits ? tsum_wide[TOTAL_W-1:0]
                              : (tsum_wide[TOTAL_W+1] ? S48_MIN : S48_MAX);
  assign mov_fits  = (&cmd_q.moved[MOVED_X_W-1:MOVED_W-1])
                  || !(|cmd_q.moved[MOVED_X_W-1:MOVED_W-1]);
  assign moved_sat = mov_fits ? cmd_q.moved[MOVED_W-1:0]
                              : (cmd_q.moved[MOVED_X_W-1] ? S40_MIN : S40_MAX);

  // Sequencer: speed A, speed B, cap, then the result word.
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    ld_cmd  = 1'b0;
    ld_div  = 1'b0;
    st_res  = 1'b0;
    fin     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          ld_cmd  = 1'b1;
          ph_d    = PH_A;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        unique case (ph_q)
          PH_A: begin
            if (cmd_q.upd_a) begin
              ld_div  = 1'b1;
              state_d = ST_START;
            end else begin
              ph_d = PH_B;
            end
          end
          PH_B: begin
            if (cmd_q.upd_b) begin
              ld_div  = 1'b1;
              state_d = ST_START;
            end else begin
              ph_d = PH_C;
            end
          end
          PH_C: begin
            if (cmd_q.cap_en) begin
              ld_div  = 1'b1;
              state_d = ST_START;
            end else begin
              state_d = ST_FINISH;
            end
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp_i.done) begin
          st_res = 1'b1;
          unique case (ph_q)
            PH_A: begin
              ph_d    = PH_B;
              state_d = ST_LOAD;
            end
            PH_B: begin
              ph_d    = PH_C;
              state_d = ST_LOAD;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (fin) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign pop_o           = ld_cmd;
  assign div_req_o.start = (state_q == ST_START);
  assign div_req_o.num   = num_q;
  assign div_req_o.den   = den_q;

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_A;
      out_valid_q <= 1'b0;
      speed_a_q   <= '0;
      speed_b_q   <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      if (st_res && (ph_q == PH_A)) begin
        speed_a_q <= sat_speed(div_rsp_i.quot, div_rsp_i.ovf, cmd_q.da[COUNT_W-1]);
      end
      if (st_res && (ph_q == PH_B)) begin
        speed_b_q <= sat_speed(div_rsp_i.quot, div_rsp_i.ovf, cmd_q.db[COUNT_W-1]);
      end
      if (fin) begin
        total_q <= total_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dpt2k_q <= {{(DPT2K_W - DPT_W){1'b0}}, cfg_dpt_i} * DPT2K_W'(SPEED_SCALE);
    dpt1k_q <= {{(DPT1K_W - DPT_W){1'b0}}, cfg_dpt_i} * DPT1K_W'(CAP_SCALE);
    if (ld_cmd) begin
      cmd_q <= cmd_i;
    end
    if (ld_div) begin
      num_q <= num_sel;
      den_q <= den_sel;
    end
    if (st_res && (ph_q == PH_C)) begin
      cap_q <= div_rsp_i.quot[DPT1K_W-1:0];
    end
    if (fin) begin
      vel_out_q   <= vel_fin;
      moved_out_q <= moved_sat;
      tsum_out_q  <= cmd_q.tick_sum;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.velocity_mm_s = vel_out_q;
  assign out_o.moved_um      = moved_out_q;
  assign out_o.total_um      = total_q;
  assign out_o.tick_sum      = tsum_out_q;

  // Checks on sequencing against the divider and the output register.
  `DOS_ASSERT_IMPL(a_div_start_free, clk_i, rst_ni, div_req_o.start, !div_rsp_i.busy, "divider started while busy")
  `DOS_ASSERT_IMPL(a_speed_a_src, clk_i, rst_ni, speed_a_q != $past(speed_a_q), $past(state_q == ST_WAIT && ph_q == PH_A), "speed A changed outside its division")
  `DOS_ASSERT_IMPL(a_out_rise_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_FINISH), "result word raised outside finish")
  `DOS_ASSERT_NEXT(a_finish_leaves, clk_i, rst_ni, state_q == ST_FINISH && (!out_valid_q || out_o.ready), out_valid_q && state_q == ST_IDLE, "finish did not deliver a word")
endmodule

/* hw/rtl/dual_odometer_speed_estimator.sv */
// ----------------------------------------------------------------------------
// Dual odometer speed estimator
// A report passes through the queue to the back end, which runs up to three
// divisions (speed A, speed B, cap) on the shared one-bit-per-cycle divider;
// a division whose quotient overflows ends without iterating.
// The back end takes one report per pass; a two-entry queue absorbs bursts
// and keeps accepting reports while the back end is busy, until it is full.
// Reset clears the stored report, speeds and total; registers take defaults.
// ----------------------------------------------------------------------------
module dual_odometer_speed_estimator #(
  parameter int unsigned FIFO_DEPTH = dos_pkg::FIFO_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dos_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dos_pkg::CFG_W-1:0]       cfg_wdata_i,
  dos_in_if.sink                          in_i,
  dos_out_if.source                       out_o
);
  import dos_pkg::*;

  logic [DPT_W-1:0]     dpt_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  logic         push, full, pop, empty;
  dos_cmd_t     cmd_push, cmd_head;
  dos_div_req_t div_req;
  dos_div_rsp_t div_rsp;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpt_q     <= DPT_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIST_PER_TICK: dpt_q     <= cfg_wdata_i[DPT_W-1:0];
        REG_STALE_TIMEOUT: timeout_q <= cfg_wdata_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  dos_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .cfg_dpt_i     (dpt_q),
    .cfg_timeout_i (timeout_q),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (cmd_push)
  );

  dos_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_push),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .empty_o (empty)
  );

  dos_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dos_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_dpt_i (dpt_q),
    .empty_i   (empty),
    .cmd_i     (cmd_head),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .out_o     (out_o)
  );
endmodule

/* verif/dos_speed_checker.sv */
// ----------------------------------------------------------------------------
// Dual odometer speed estimator checker
// Watches the report and result channels and the register port. It predicts
// every result word from its own copy of the channel state and registers,
// and compares each accepted result word field by field, in order.
// ----------------------------------------------------------------------------
module dos_speed_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dos_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dos_pkg::CFG_W-1:0]     cfg_wdata_i,
  dos_in_if                             rpt_i,
  dos_out_if                            res_i,
  output int unsigned                   outstanding_o,
  output int unsigned                   mismatches_o
);
  import dos_pkg::*;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S40_MAX = 64'sd549755813887;
  localparam longint S40_MIN = -64'sd549755813888;
  localparam longint S48_MAX = 64'sd140737488355327;
  localparam longint S48_MIN = -64'sd140737488355328;

  typedef struct {
    logic signed [VEL_W-1:0]   velocity;
    logic signed [MOVED_W-1:0] moved;
    logic signed [TOTAL_W-1:0] total;
    logic signed [TSUM_W-1:0]  tick_sum;
  } speed_result_t;

  // Register copies.
  logic [DPT_W-1:0]     tick_len_um;
  logic [TIMEOUT_W-1:0] idle_limit_us;

  // Channel state as last reported, and the running estimates.
  logic [COUNT_W-1:0] last_count_a;
  logic [COUNT_W-1:0] last_count_b;
  logic [TIME_W-1:0]  last_stamp_a;
  logic [TIME_W-1:0]  last_stamp_b;
  longint             chan_a_speed;
  longint             chan_b_speed;
  longint             odo_total;

  speed_result_t estimates_due[$];
  int unsigned   mismatches;

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Speed of one channel in mm/s over a nonzero time step, truncated toward zero.
  function automatic longint tick_speed(input longint dticks, input logic [TIME_W-1:0] dt);
    longint unsigned mag;
    longint unsigned quot;
    longint          spd;
    mag  = (dticks < 0) ? -dticks : dticks;
    quot = mag * 64'd2 * {48'd0, tick_len_um} * 64'd1000 / {32'd0, dt};
    spd  = (dticks < 0) ? -longint'(quot) : longint'(quot);
    return saturate(spd, S32_MIN, S32_MAX);
  endfunction

  // Works out the result word for one report and advances the channel state.
  function automatic speed_result_t estimate_speed(input logic [TIME_W-1:0] now, ca, ta, cb, tb);
    logic signed [COUNT_W-1:0] dcount_a;
    logic signed [COUNT_W-1:0] dcount_b;
    logic signed [COUNT_W-1:0] sa;
    logic signed [COUNT_W-1:0] sb;
    logic [TIME_W-1:0]         tick_now;
    logic [TIME_W-1:0]         tick_prev;
    logic [TIME_W-1:0]         elapsed;
    longint                    da;
    longint                    db;
    longint                    vel;
    longint                    cap;
    longint                    mag;
    longint                    moved;
    longint                    tsum;
    speed_result_t             r;
    dcount_a = ca - last_count_a;
    dcount_b = cb - last_count_b;
    da = dcount_a;
    db = dcount_b;

    // A channel only gets a new speed when its tick timestamp changed.
    if (ta != last_stamp_a) chan_a_speed = tick_speed(da, ta - last_stamp_a);
    if (tb != last_stamp_b) chan_b_speed = tick_speed(db, tb - last_stamp_b);
    vel = (chan_a_speed + chan_b_speed) / 2;

    // With no fresh tick the velocity goes to zero when stale, else is capped.
    tick_now  = (ta > tb) ? ta : tb;
    tick_prev = (last_stamp_a > last_stamp_b) ? last_stamp_a : last_stamp_b;
    if (tick_now == tick_prev) begin
      elapsed = now - tick_prev;
      if (elapsed > idle_limit_us) begin
        vel = 0;
      end else if (elapsed != 0) begin
        cap = {48'd0, tick_len_um} * 64'd1000 / {32'd0, elapsed};
        mag = (vel < 0) ? -vel : vel;
        if (cap < mag) vel = (vel > 0) ? cap : -cap;
      end
    end

    moved     = (da + db) * longint'({48'd0, tick_len_um});
    odo_total = saturate(odo_total + moved, S48_MIN, S48_MAX);
    moved     = saturate(moved, S40_MIN, S40_MAX);
    sa   = ca;
    sb   = cb;
    tsum = sa;
    tsum = tsum + sb;

    r.velocity = vel[VEL_W-1:0];
    r.moved    = moved[MOVED_W-1:0];
    r.total    = odo_total[TOTAL_W-1:0];
    r.tick_sum = tsum[TSUM_W-1:0];

    last_count_a = ca;
    last_count_b = cb;
    last_stamp_a = ta;
    last_stamp_b = tb;
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Result words are checked before a report of the same edge is predicted,
  // since a result can never belong to a report accepted at that edge.
  always @(posedge clk_i or negedge rst_ni) begin
    speed_result_t want;
    if (!rst_ni) begin
      tick_len_um   = DPT_RESET;
      idle_limit_us = TIMEOUT_RESET;
      last_count_a  = '0;
      last_count_b  = '0;
      last_stamp_a  = '0;
      last_stamp_b  = '0;
      chan_a_speed  = 0;
      chan_b_speed  = 0;
      odo_total     = 0;
      mismatches    = 0;
      estimates_due.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (estimates_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word with no report outstanding: expected none, got %0d",
                   $time, res_i.velocity_mm_s);
        end else begin
          want = estimates_due.pop_front();
          check_field("velocity_mm_s", want.velocity, res_i.velocity_mm_s);
          check_field("moved_um", want.moved, res_i.moved_um);
          check_field("total_um", want.total, res_i.total_um);
          check_field("tick_sum", want.tick_sum, res_i.tick_sum);
        end
      end
      if (rpt_i.valid && rpt_i.ready)
        estimates_due.push_back(estimate_speed(rpt_i.clock_now_us, rpt_i.count_a,
                                               rpt_i.time_a_us, rpt_i.count_b,
                                               rpt_i.time_b_us));
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_DIST_PER_TICK) tick_len_um = cfg_wdata_i[DPT_W-1:0];
        else if (cfg_idx_i == REG_STALE_TIMEOUT) idle_limit_us = cfg_wdata_i[TIMEOUT_W-1:0];
      end
    end
    outstanding_o <= estimates_due.size();
    mismatches_o  <= mismatches;
  end

endmodule

/* verif/tb_dual_odometer_speed_estimator.sv */
// ----------------------------------------------------------------------------
// Dual odometer speed estimator testbench
// Drives directed sensor reports through fresh ticks, capped, stale and
// zero-elapsed cases under extreme register values, then phases of random
// well-formed tick sequences mixed with noise. Both channels idle at random.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_odometer_speed_estimator;
  import dos_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 50;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  dos_in_if  rpt_ch ();
  dos_out_if res_ch ();

  int unsigned outstanding;
  int unsigned mismatches;

  // Last report sent, the base for the next well-formed report.
  logic [TIME_W-1:0] sim_now;
  logic [TIME_W-1:0] sim_ca;
  logic [TIME_W-1:0] sim_ta;
  logic [TIME_W-1:0] sim_cb;
  logic [TIME_W-1:0] sim_tb;
  bit                steady;
  int unsigned       n_reports;
  int unsigned       n_settings;

  dual_odometer_speed_estimator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (rpt_ch),
    .out_o       (res_ch)
  );

  dos_speed_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rpt_i         (rpt_ch),
    .res_i         (res_ch),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_W-1:0] tick_jump();
    if ($urandom_range(0, 99) < 5) return $urandom();
    return $urandom_range(0, 60) - 30;
  endfunction

  function automatic logic [DPT_W-1:0] pick_tick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd1;
    if (r < 30) return 16'hFFFF;
    if (r < 35) return 16'd0;
    return DPT_W'($urandom_range(1, 5000));
  endfunction

  function automatic logic [TIMEOUT_W-1:0] pick_timeout();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'd1;
    if (r < 30) return 32'hFFFF_FFFF;
    if (r < 35) return 32'd0;
    return $urandom_range(500, 200000);
  endfunction

  // Sends one report word and returns at the edge where it is accepted.
  task automatic send_report(input logic [TIME_W-1:0] now, ca, ta, cb, tb);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      rpt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rpt_ch.valid        <= 1'b1;
    rpt_ch.clock_now_us <= now;
    rpt_ch.count_a      <= ca;
    rpt_ch.time_a_us    <= ta;
    rpt_ch.count_b      <= cb;
    rpt_ch.time_b_us    <= tb;
    @(posedge clk_i);
    while (!rpt_ch.ready) @(posedge clk_i);
    sim_now = now;
    sim_ca  = ca;
    sim_ta  = ta;
    sim_cb  = cb;
    sim_tb  = tb;
    n_reports++;
  endtask

  // Stops sending and waits until every predicted result word has arrived.
  task automatic drain();
    rpt_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Both registers are written back to back while the block is idle.
  task automatic set_registers(input logic [DPT_W-1:0] tick_len, input logic [TIMEOUT_W-1:0] limit);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DIST_PER_TICK;
    cfg_wdata_i <= {{(CFG_W-DPT_W){1'b0}}, tick_len};
    @(posedge clk_i);
    cfg_idx_i   <= REG_STALE_TIMEOUT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  // Mostly a plausible next report: time advances, channels tick now and then.
  // The rest is noise or reports that run backward in time.
  task automatic random_report();
    int unsigned       r;
    logic [TIME_W-1:0] advance;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] ca;
    logic [TIME_W-1:0] ta;
    logic [TIME_W-1:0] cb;
    logic [TIME_W-1:0] tb;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_report($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    end else if (r < 20) begin
      send_report(sim_now - $urandom_range(0, 500), sim_ca + tick_jump(),
                  sim_ta - $urandom_range(1, 5000), sim_cb - tick_jump(),
                  sim_tb + $urandom_range(1, 5000));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 6) advance = 0;
      else if (r < 90) advance = $urandom_range(1, 3000);
      else advance = $urandom_range(3000, 400000);
      now = sim_now + advance;
      ca  = sim_ca;
      ta  = sim_ta;
      cb  = sim_cb;
      tb  = sim_tb;
      if ($urandom_range(0, 99) < 55) begin
        ca = sim_ca + tick_jump();
        ta = now - $urandom_range(0, 40);
      end
      if ($urandom_range(0, 99) < 55) begin
        cb = sim_cb + tick_jump();
        tb = now - $urandom_range(0, 40);
      end
      send_report(now, ca, ta, cb, tb);
    end
  endtask

  // Result side: ready for one cycle, then an idle stretch of random length, none in steady phases.
  initial begin : result_sink
    int unsigned hold;
    res_ch.ready = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (steady || hold == 0) begin
        res_ch.ready <= 1'b1;
        hold = idle_cycles();
      end else begin
        res_ch.ready <= 1'b0;
        hold--;
      end
    end
  end

  // Ends the run when no word moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((rpt_ch.valid && rpt_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL dual_odometer_speed_estimator");
    $finish;
  end

  initial begin : stimulus
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_DIST_PER_TICK;
    cfg_wdata_i         = '0;
    rpt_ch.valid        = 1'b0;
    rpt_ch.clock_now_us = '0;
    rpt_ch.count_a      = '0;
    rpt_ch.time_a_us    = '0;
    rpt_ch.count_b      = '0;
    rpt_ch.time_b_us    = '0;
    steady              = 1'b0;
    sim_now             = '0;
    sim_ca              = '0;
    sim_ta              = '0;
    sim_cb              = '0;
    sim_tb              = '0;
    n_reports           = 0;
    n_settings          = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: zero elapsed, cap, fresh ticks, stale and wrapping time.
    send_report(0, 0, 0, 0, 0);
    send_report(50, 0, 0, 0, 0);
    send_report(1000, 10, 1000, 0, 0);
    send_report(2000, 10, 1000, 5, 2000);
    send_report(2500, 10, 1000, 5, 2000);
    send_report(2000, 10, 1000, 5, 2000);
    send_report(202001, 10, 1000, 5, 2000);
    send_report(300001, -20, 300000, -30, 300001);
    send_report(300003, 32'h7FFF_FFFF, 300002, 32'h8000_0000, 300003);
    send_report(300004, 32'h8000_0000, 300004, 32'h7FFF_FFFF, 300004);
    send_report(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFE);
    send_report(4, 3, 2, 1, 32'hFFFF_FFFF);
    send_report(0, 3, 2, 1, 32'hFFFF_FFFF);

    // Largest distance and timeout: saturated distances, cap over long gaps.
    set_registers(16'hFFFF, 32'hFFFF_FFFF);
    send_report(10, 32'h7FFF_FFFF, 7, 32'h7FFF_FFFF, 8);
    send_report(20, 32'h7FFF_FFFF, 7, 32'h7FFF_FFFF, 8);
    send_report(32'h8000_0000, 32'h7FFF_FFFF, 7, 32'h7FFF_FFFF, 8);
    send_report(40, 0, 30, 0, 40);

    // Zero registers: zero speeds, stale at any nonzero elapsed time, zero elapsed.
    set_registers(16'd0, 32'd0);
    send_report(50, 5, 45, 6, 50);
    send_report(60, 5, 45, 6, 50);
    send_report(50, 5, 45, 6, 50);

    // Smallest nonzero registers: right at the timeout and just past it.
    set_registers(16'd1, 32'd1);
    send_report(100, 9, 90, 9, 100);
    send_report(101, 9, 90, 9, 100);
    send_report(102, 9, 90, 9, 100);

    // Random phases, each with its own register setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      set_registers(pick_tick_len(), pick_timeout());
      steady = (phase % 3 == 2);
      if (phase == 5) begin
        sim_now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        sim_ta  = sim_now;
        sim_tb  = sim_now;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 4 && k == PHASE_ITEMS / 2) drain();
        random_report();
      end
    end
    steady = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d sensor reports under %0d register settings,", n_reports, n_settings);
    $display("covering fresh, capped, stale, saturating and wrapping cases.");
    if (mismatches == 0) begin
      $display("PASS dual_odometer_speed_estimator");
    end else begin
      $display("FAIL dual_odometer_speed_estimator");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/dos_pkg.sv
hw/rtl/dos_in_if.sv
hw/rtl/dos_out_if.sv
hw/rtl/dos_front.sv
hw/rtl/dos_fifo.sv
hw/rtl/dos_div.sv
hw/rtl/dos_back.sv
hw/rtl/dual_odometer_speed_estimator.sv
verif/dos_speed_checker.sv
verif/tb_dual_odometer_speed_estimator.sv
